// ----- sv/sbkct_pkg.sv -----
// Shared types and constants of the sorted byte-key child table.
package sbkct_pkg;

    localparam int MODE_W   = 3;
    localparam int KEY_W    = 8;
    localparam int PORT_HW  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 3'd0,
        MODE_LOOKUP  = 3'd1,
        MODE_INSERT  = 3'd2,
        MODE_DELETE  = 3'd3,
        MODE_REPLACE = 3'd4,
        MODE_NEXT    = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_SINGLE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

// ----- sv/sbkct_in_if.sv -----
// Input channel interface: one operation word per handshake.
interface sbkct_in_if;
    logic                             valid;
    logic                             ready;
    logic [sbkct_pkg::MODE_W-1:0]     mode;
    logic [sbkct_pkg::KEY_W-1:0]      key_byte;
    logic [sbkct_pkg::PORT_HW-1:0]    child_handle;

    modport source (output valid, output mode, output key_byte, output child_handle,
                    input ready);
    modport sink   (input valid, input mode, input key_byte, input child_handle,
                    output ready);
endinterface

// ----- sv/sbkct_out_if.sv -----
// Output channel interface: one result word per handshake.
interface sbkct_out_if;
    logic                             valid;
    logic                             ready;
    logic [sbkct_pkg::STATUS_W-1:0]   status;
    logic [sbkct_pkg::KEY_W-1:0]      found_key;
    logic [sbkct_pkg::PORT_HW-1:0]    found_handle;
    logic [sbkct_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, output status, output found_key, output found_handle,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_key, input found_handle,
                    input entry_count, output ready);
endinterface

// ----- sv/sbkct_ctrl.sv -----
// Controller state machine: sequences load, compare and execute of one word.
module sbkct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbkct_pkg::t_stat  i_stat,
    output sbkct_pkg::t_cmd   o_cmd
);

    sbkct_pkg::t_state r_state;
    sbkct_pkg::t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbkct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through compare and execute; wait in execute while the result slot is full
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbkct_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sbkct_pkg::S_CMP;
            end
            sbkct_pkg::S_CMP: begin
                n_state = sbkct_pkg::S_EXEC;
            end
            sbkct_pkg::S_EXEC: begin
                if (!i_stat.out_busy) n_state = sbkct_pkg::S_IDLE;
            end
            default: begin
                n_state = sbkct_pkg::S_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.compare = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            sbkct_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sbkct_pkg::S_CMP: begin
                o_cmd.compare = 1'b1;
            end
            sbkct_pkg::S_EXEC: begin
                o_cmd.exec = !i_stat.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/sbkct_dp.sv -----
// Datapath: key and handle table, parallel compare, shift update, result register.
module sbkct_dp #(
    parameter int CAPACITY    = 4,
    parameter int HANDLE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbkct_pkg::t_cmd                   i_cmd,
    output sbkct_pkg::t_stat                  o_stat,
    input  logic [sbkct_pkg::MODE_W-1:0]      i_mode,
    input  logic [sbkct_pkg::KEY_W-1:0]       i_key,
    input  logic [sbkct_pkg::PORT_HW-1:0]     i_handle,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [sbkct_pkg::STATUS_W-1:0]    o_status,
    output logic [sbkct_pkg::KEY_W-1:0]       o_found_key,
    output logic [sbkct_pkg::PORT_HW-1:0]     o_found_handle,
    output logic [sbkct_pkg::COUNT_W-1:0]     o_entry_count
);

    localparam int HW = (HANDLE_BITS < sbkct_pkg::PORT_HW) ? HANDLE_BITS : sbkct_pkg::PORT_HW;
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = sbkct_pkg::KEY_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    // Table and entry count
    logic [KW-1:0]        r_keys    [CAPACITY];
    logic [HW-1:0]        r_handles [CAPACITY];
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    // Latched operation word and compare results
    sbkct_pkg::t_mode     r_mode;
    logic [KW-1:0]        r_key;
    logic [HW-1:0]        r_handle;
    logic [CW-1:0]        r_pos;
    logic                 r_hit;

    // Result register
    logic                 r_out_valid;
    sbkct_pkg::t_status   r_status;
    logic [KW-1:0]        r_found_key;
    logic [HW-1:0]        r_found_handle;
    logic [CW-1:0]        r_out_count;

    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;
    logic [KW-1:0]        up_key    [CAPACITY];
    logic [HW-1:0]        up_handle [CAPACITY];
    logic [KW-1:0]        dn_key    [CAPACITY];
    logic [HW-1:0]        dn_handle [CAPACITY];

    logic                 pos_ok;
    logic [KW-1:0]        rd_key;
    logic [HW-1:0]        rd_handle;
    logic                 do_clr;
    logic                 do_ins;
    logic                 do_del;
    logic                 do_rep;
    sbkct_pkg::t_status   n_status;
    logic [KW-1:0]        n_found_key;
    logic [HW-1:0]        n_found_handle;

    // Latch the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= sbkct_pkg::t_mode'(i_mode);
            r_key    <= i_key;
            r_handle <= i_handle[HW-1:0];
        end
    end

    // Compare every valid entry against the key in parallel
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt_vec[i] = (CW'(i) < r_count) && (r_keys[i] < r_key);
            eq_vec[i] = (CW'(i) < r_count) && (r_keys[i] == r_key);
        end
    end

    // Keys are sorted: the count of smaller keys is the match, insert and next slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_pos <= CW'($countones(lt_vec));
            r_hit <= |eq_vec;
        end
    end

    // Neighbor taps for the shift-up and shift-down moves
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_tap
            if (gi == 0) begin : g_first
                assign up_key[gi]    = '0;
                assign up_handle[gi] = '0;
            end else begin : g_up
                assign up_key[gi]    = r_keys[gi-1];
                assign up_handle[gi] = r_handles[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign dn_key[gi]    = '0;
                assign dn_handle[gi] = '0;
            end else begin : g_dn
                assign dn_key[gi]    = r_keys[gi+1];
                assign dn_handle[gi] = r_handles[gi+1];
            end
        end
    endgenerate

    // Read the selected slot
    assign pos_ok    = r_pos < CAP_C;
    assign rd_key    = pos_ok ? r_keys[r_pos[IW-1:0]]    : '0;
    assign rd_handle = pos_ok ? r_handles[r_pos[IW-1:0]] : '0;

    // Decode the operation into an update and a result
    always_comb begin
        do_clr         = 1'b0;
        do_ins         = 1'b0;
        do_del         = 1'b0;
        do_rep         = 1'b0;
        n_status       = sbkct_pkg::ST_NOT_FOUND;
        n_found_key    = '0;
        n_found_handle = '0;
        case (r_mode)
            sbkct_pkg::MODE_CLEAR: begin
                do_clr   = 1'b1;
                n_status = sbkct_pkg::ST_OK;
            end
            sbkct_pkg::MODE_LOOKUP: begin
                if (r_hit) begin
                    n_status       = sbkct_pkg::ST_OK;
                    n_found_key    = r_key;
                    n_found_handle = rd_handle;
                end
            end
            sbkct_pkg::MODE_INSERT: begin
                if (r_hit) begin
                    n_status       = sbkct_pkg::ST_DUPLICATE;
                    n_found_key    = r_key;
                    n_found_handle = rd_handle;
                end else if (r_count >= CAP_C) begin
                    n_status = sbkct_pkg::ST_FULL;
                end else begin
                    do_ins         = 1'b1;
                    n_status       = sbkct_pkg::ST_OK;
                    n_found_key    = r_key;
                    n_found_handle = r_handle;
                end
            end
            sbkct_pkg::MODE_DELETE: begin
                if (r_hit) begin
                    do_del         = 1'b1;
                    n_status       = (r_count == TWO_C) ? sbkct_pkg::ST_SINGLE
                                                        : sbkct_pkg::ST_OK;
                    n_found_key    = r_key;
                    n_found_handle = rd_handle;
                end
            end
            sbkct_pkg::MODE_REPLACE: begin
                if (r_hit) begin
                    do_rep         = 1'b1;
                    n_status       = sbkct_pkg::ST_OK;
                    n_found_key    = r_key;
                    n_found_handle = r_handle;
                end
            end
            sbkct_pkg::MODE_NEXT: begin
                if (r_pos < r_count) begin
                    n_status       = sbkct_pkg::ST_OK;
                    n_found_key    = rd_key;
                    n_found_handle = rd_handle;
                end
            end
            default: begin
                n_status = sbkct_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // Next entry count
    always_comb begin
        n_count = r_count;
        if (do_clr) begin
            n_count = '0;
        end else if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    // Shift the table up on insert, down on delete; overwrite on replace
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (do_ins) begin
                    if (CW'(i) == r_pos) begin
                        r_keys[i]    <= r_key;
                        r_handles[i] <= r_handle;
                    end else if (CW'(i) > r_pos) begin
                        r_keys[i]    <= up_key[i];
                        r_handles[i] <= up_handle[i];
                    end
                end else if (do_del) begin
                    if (CW'(i) >= r_pos && i < CAPACITY - 1) begin
                        r_keys[i]    <= dn_key[i];
                        r_handles[i] <= dn_handle[i];
                    end
                end else if (do_rep && CW'(i) == r_pos) begin
                    r_handles[i] <= r_handle;
                end
            end
        end
    end

    // Control registers: entry count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status       <= n_status;
            r_found_key    <= n_found_key;
            r_found_handle <= n_found_handle;
            r_out_count    <= n_count;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_key     = r_found_key;
    assign o_found_handle  = sbkct_pkg::PORT_HW'(r_found_handle);
    assign o_entry_count   = sbkct_pkg::COUNT_W'(r_out_count);

    // Entry count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // Count moves only on an execute cycle
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cmd.exec)) |-> $stable(r_count))
        else $error("entry count changed outside execute");

    // An execute always leaves a pending result
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("execute without a result");

    // Valid keys stay strictly ascending
    generate
        for (gi = 0; gi < CAPACITY - 1; gi++) begin : g_sorted
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (CW'(gi + 1) < r_count) |-> (r_keys[gi] < r_keys[gi+1]))
                else $error("keys out of order");
        end
    endgenerate

endmodule

// ----- sv/sorted_byte_key_child_table.sv -----
// Top level: one radix-tree node table of byte keys with child handles.
//
// Usage: i_in carries one operation word (mode, key_byte, child_handle); o_out
// returns exactly one result word (status, found_key, found_handle,
// entry_count) for each accepted operation, in order.
// Modes: clear, lookup, insert, delete, replace, and next key at or above.
// Timing: an accepted word is loaded, then all entries are compared in parallel,
// then execute applies the shift update and makes the result valid, provided
// the result register is empty or being drained. i_in.ready is high only while
// the controller is idle, so a new word is not taken until the last one executes.
// Stall: while o_out holds an untaken result, the next word is still accepted
// and compared, and waits in execute until the result register frees up.
// Reset (synchronous, i_rst_n low) empties the table and drops any pending
// result; no clearing pass is needed.
// CAPACITY sets the number of entries; HANDLE_BITS sets how many low bits of
// the handle are kept (at most 32).
module sorted_byte_key_child_table #(
    parameter int CAPACITY    = 4,
    parameter int HANDLE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbkct_in_if.sink     i_in,
    sbkct_out_if.source  o_out
);

    sbkct_pkg::t_cmd  cmd;
    sbkct_pkg::t_stat stat;

    // Sequence each word
    sbkct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the table and compute results
    sbkct_dp #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_in.mode),
        .i_key          (i_in.key_byte),
        .i_handle       (i_in.child_handle),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_found_key    (o_out.found_key),
        .o_found_handle (o_out.found_handle),
        .o_entry_count  (o_out.entry_count)
    );

endmodule
